// ===== rtl/bfrm_pkg.sv =====
// Shared types, sizes and codes for the blanket roughness map block.
// No dependencies; the datapath, controller, top level and checker import this package.
`default_nettype none
package bfrm_pkg;
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int XW   = $clog2(MAX_WIDTH);
  localparam int YW   = $clog2(MAX_HEIGHT);
  localparam int WDW  = $clog2(MAX_WIDTH + 1);
  localparam int HDW  = $clog2(MAX_HEIGHT + 1);
  localparam int AW   = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int TW   = AW + 1;
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int CFGW = 9;
  localparam int PW   = 8;
  localparam int DW   = 9;
  localparam int SW   = 13;
  localparam int NW   = SW + 8;
  localparam int CW   = $clog2(NW + 1);

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;
  localparam logic MODE_BLANKET = 1'b0;
  localparam logic MODE_SUM     = 1'b1;

  typedef struct packed {
    logic          opcode;
    logic [PW-1:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [PW-1:0] map_pixel;
    logic          last_pixel;
  } out_item_t;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_BL_PIX = 10'b0000000010,
    S_BL_TAP = 10'b0000000100,
    S_BL_DRN = 10'b0000001000,
    S_BL_WR  = 10'b0000010000,
    S_SM_PIX = 10'b0000100000,
    S_SM_TAP = 10'b0001000000,
    S_SM_DRN = 10'b0010000000,
    S_SM_WR  = 10'b0100000000,
    S_RD     = 10'b1000000000
  } state_t;

  typedef struct packed {
    logic load_wr;
    logic load_restart;
    logic pix_clr;
    logic tap_clr;
    logic tap_issue;
    logic mode;
    logic pix_wr;
    logic rd_issue;
    logic div_start;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic wp_last;
    logic total_one;
    logic interior;
    logic tap_done;
    logic pix_last;
    logic div_done;
    logic out_free;
  } status_t;
endpackage
`default_nettype wire

// ===== rtl/bfrm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module bfrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/bfrm_datapath.sv =====
// Datapath: image, blanket and window-sum stores, walk counters, divider, output register.
// Depends on bfrm_pkg and bfrm_ram.
`default_nettype none
module bfrm_datapath (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic                       cfg_idx,
  input  wire logic [bfrm_pkg::CFGW-1:0]  cfg_data,
  input  wire logic [bfrm_pkg::PW-1:0]    pixel_in,
  input  wire bfrm_pkg::cmd_t             cmd,
  output bfrm_pkg::status_t               st,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output bfrm_pkg::out_item_t             out_item
);
  import bfrm_pkg::*;

  logic [WDW-1:0] w_r;
  logic [HDW-1:0] h_r;
  logic [TW-1:0]  total;
  logic [AW-1:0]  wp_r, rp_r, pix_r;
  logic [XW-1:0]  x_r, rx_r;
  logic [YW-1:0]  y_r, ry_r;
  logic [2:0]     ti_r, tj_r, tlast, trad;
  logic           rd_vld_r, ctr_d_r;
  logic [PW-1:0]  mx_r, mn_r, pc_r;
  logic [SW-1:0]  acc_r, max_r;
  logic [NW-1:0]  num_r;
  logic [SW-1:0]  rem_r;
  logic [CW-1:0]  cnt_r;
  logic [YW:0]    yy;
  logic [XW:0]    xx;
  logic [AW-1:0]  nb_addr, wr_addr;
  logic [PW-1:0]  pix_q;
  logic [DW-1:0]  diff_q, diff_val;
  logic [SW-1:0]  sum_q;
  logic [9:0]     up, lo, dsub;
  logic [SW:0]    trial;
  logic           qbit, reg4_rd, reg4_px;
  logic [PW-1:0]  map_val;

  // pixel lies at least m from every edge
  function automatic logic in_region(input logic [XW-1:0] x, input logic [YW-1:0] y,
                                     input logic [WDW-1:0] w, input logic [HDW-1:0] h,
                                     input logic [2:0] m);
    in_region = ({1'b0, x} >= (XW+1)'(m)) && ({1'b0, y} >= (YW+1)'(m)) &&
                ((WDW+1)'(x) + (WDW+1)'(m) < (WDW+1)'(w)) &&
                ((HDW+1)'(y) + (HDW+1)'(m) < (HDW+1)'(h));
  endfunction

  assign total   = TW'(w_r) * TW'(h_r);
  assign tlast   = (cmd.mode == MODE_SUM) ? 3'd4 : 3'd2;
  assign trad    = (cmd.mode == MODE_SUM) ? 3'd2 : 3'd1;
  assign yy      = (YW+1)'(y_r) + (YW+1)'(ti_r) - (YW+1)'(trad);
  assign xx      = (XW+1)'(x_r) + (XW+1)'(tj_r) - (XW+1)'(trad);
  assign nb_addr = AW'(yy[YW-1:0]) * AW'(w_r) + AW'(xx[XW-1:0]);
  assign wr_addr = cmd.load_restart ? '0 : wp_r;

  // status towards the controller
  always_comb begin
    st.wp_last   = (TW'(wp_r) + TW'(1)) == total;
    st.total_one = total == TW'(1);
    st.interior  = in_region(x_r, y_r, w_r, h_r, trad);
    st.tap_done  = (ti_r == tlast) && (tj_r == tlast);
    st.pix_last  = ((WDW'(x_r) + WDW'(1)) == w_r) && ((HDW'(y_r) + HDW'(1)) == h_r);
    st.div_done  = cnt_r == '0;
    st.out_free  = !out_valid || !out_stall;
  end

  // blanket difference from the gathered extremes
  always_comb begin
    up       = (mx_r > pc_r) ? 10'(mx_r) : 10'(pc_r) + 10'd1;
    lo       = (mn_r < pc_r) ? 10'(mn_r) : 10'(pc_r) - 10'd1;
    dsub     = up - lo;
    diff_val = st.interior ? dsub[DW-1:0] : '0;
  end

  // one restoring divide step
  always_comb begin
    trial = {rem_r, num_r[NW-1]};
    qbit  = trial >= {1'b0, max_r};
  end

  assign reg4_rd = in_region(rx_r, ry_r, w_r, h_r, 3'd4);
  assign reg4_px = in_region(x_r, y_r, w_r, h_r, 3'd4);
  assign map_val = (num_r[NW-1:PW] != '0) ? {PW{1'b1}} : num_r[PW-1:0];

  bfrm_ram #(.WIDTH(PW), .DEPTH(DEPTH)) u_pix (
    .clk, .we(cmd.load_wr), .waddr(wr_addr), .wdata(pixel_in),
    .raddr(nb_addr), .rdata(pix_q));
  bfrm_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_diff (
    .clk, .we(cmd.pix_wr && cmd.mode == MODE_BLANKET), .waddr(pix_r), .wdata(diff_val),
    .raddr(nb_addr), .rdata(diff_q));
  bfrm_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_sum (
    .clk, .we(cmd.pix_wr && cmd.mode == MODE_SUM), .waddr(pix_r),
    .wdata(st.interior ? acc_r : '0), .raddr(rp_r), .rdata(sum_q));

  // control counters and flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r <= WDW'(MAX_WIDTH);
      h_r <= HDW'(MAX_HEIGHT);
      wp_r <= '0; rp_r <= '0; rx_r <= '0; ry_r <= '0;
      rd_vld_r <= 1'b0; cnt_r <= '0; out_valid <= 1'b0; max_r <= '0;
    end else begin
      rd_vld_r <= cmd.tap_issue;
      if (cmd.load_wr) begin
        if ((cmd.load_restart && st.total_one) || (!cmd.load_restart && st.wp_last)) begin
          wp_r <= '0;
        end else begin
          wp_r <= wr_addr + AW'(1);
        end
        if (cmd.load_restart) begin
          rp_r <= '0; rx_r <= '0; ry_r <= '0;
        end
      end
      if (cmd.pix_clr) begin
        max_r <= '0;
      end else if (cmd.pix_wr && cmd.mode == MODE_SUM && st.interior && reg4_px &&
                   acc_r > max_r) begin
        max_r <= acc_r;
      end
      if (cmd.div_start) begin
        cnt_r <= CW'(NW);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CW'(1);
      end
      // hold the result until taken, then drop it
      if (cmd.out_load) begin
        out_valid <= 1'b1;
        if ((TW'(rp_r) + TW'(1)) == total) begin
          rp_r <= '0; rx_r <= '0; ry_r <= '0;
        end else begin
          rp_r <= rp_r + AW'(1);
          if ((WDW'(rx_r) + WDW'(1)) == w_r) begin
            rx_r <= '0;
            ry_r <= ry_r + YW'(1);
          end else begin
            rx_r <= rx_r + XW'(1);
          end
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        if (cfg_idx == CFG_WIDTH) begin
          w_r <= (cfg_data == '0) ? WDW'(1) :
                 (int'(cfg_data) > MAX_WIDTH) ? WDW'(MAX_WIDTH) : WDW'(cfg_data);
        end else begin
          h_r <= (cfg_data == '0) ? HDW'(1) :
                 (int'(cfg_data) > MAX_HEIGHT) ? HDW'(MAX_HEIGHT) : HDW'(cfg_data);
        end
        wp_r <= '0; rp_r <= '0; rx_r <= '0; ry_r <= '0;
      end
    end
  end

  // walk position, taps, accumulators, divider and output payload
  always_ff @(posedge clk) begin
    ctr_d_r <= cmd.tap_issue && (ti_r == 3'd1) && (tj_r == 3'd1);
    if (cmd.pix_clr) begin
      x_r <= '0; y_r <= '0; pix_r <= '0;
    end else if (cmd.pix_wr) begin
      pix_r <= pix_r + AW'(1);
      if ((WDW'(x_r) + WDW'(1)) == w_r) begin
        x_r <= '0;
        y_r <= y_r + YW'(1);
      end else begin
        x_r <= x_r + XW'(1);
      end
    end
    if (cmd.tap_clr) begin
      ti_r <= '0; tj_r <= '0;
      mx_r <= '0; mn_r <= {PW{1'b1}}; acc_r <= '0;
    end else begin
      if (cmd.tap_issue) begin
        if (tj_r == tlast) begin
          tj_r <= '0;
          ti_r <= ti_r + 3'd1;
        end else begin
          tj_r <= tj_r + 3'd1;
        end
      end
      if (rd_vld_r) begin
        if (cmd.mode == MODE_SUM) begin
          acc_r <= acc_r + SW'(diff_q);
        end else begin
          if (pix_q > mx_r) mx_r <= pix_q;
          if (pix_q < mn_r) mn_r <= pix_q;
          if (ctr_d_r) pc_r <= pix_q;
        end
      end
    end
    if (cmd.div_start) begin
      num_r <= NW'(sum_q) * NW'(255);
      rem_r <= '0;
    end else if (cnt_r != '0) begin
      rem_r <= qbit ? SW'(trial - {1'b0, max_r}) : trial[SW-1:0];
      num_r <= {num_r[NW-2:0], qbit};
    end
    if (cmd.out_load) begin
      out_item.map_pixel  <= (reg4_rd && max_r != '0) ? map_val : '0;
      out_item.last_pixel <= (TW'(rp_r) + TW'(1)) == total;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/bfrm_ctrl.sv =====
// Controller state machine: load, two-pass compute walk and readout sequencing.
// Depends on bfrm_pkg.
`default_nettype none
module bfrm_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_opcode,
  output logic                   in_stall,
  input  wire logic              cfg_we,
  input  wire bfrm_pkg::status_t st,
  output bfrm_pkg::cmd_t         cmd
);
  import bfrm_pkg::*;

  state_t state_r, state_nxt;
  logic   computed_r, computed_nxt;
  logic   start_r;

  assign in_stall = state_r != S_IDLE;

  // next state and commands
  always_comb begin
    state_nxt    = state_r;
    computed_nxt = computed_r;
    cmd          = '0;
    cmd.mode     = MODE_BLANKET;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_opcode == OP_WRITE) begin
          cmd.load_wr      = 1'b1;
          cmd.load_restart = computed_r;
          computed_nxt     = 1'b0;
          if (computed_r ? st.total_one : st.wp_last) begin
            cmd.pix_clr = 1'b1;
            state_nxt   = S_BL_PIX;
          end
        end else if (in_valid && computed_r) begin
          cmd.rd_issue = 1'b1;
          state_nxt    = S_RD;
        end
      end
      S_BL_PIX: begin
        cmd.tap_clr = 1'b1;
        state_nxt   = st.interior ? S_BL_TAP : S_BL_WR;
      end
      S_BL_TAP: begin
        cmd.tap_issue = 1'b1;
        if (st.tap_done) state_nxt = S_BL_DRN;
      end
      S_BL_DRN: state_nxt = S_BL_WR;
      S_BL_WR: begin
        cmd.pix_wr = 1'b1;
        if (st.pix_last) begin
          cmd.pix_clr = 1'b1;
          state_nxt   = S_SM_PIX;
        end else begin
          state_nxt = S_BL_PIX;
        end
      end
      S_SM_PIX: begin
        cmd.mode    = MODE_SUM;
        cmd.tap_clr = 1'b1;
        state_nxt   = st.interior ? S_SM_TAP : S_SM_WR;
      end
      S_SM_TAP: begin
        cmd.mode      = MODE_SUM;
        cmd.tap_issue = 1'b1;
        if (st.tap_done) state_nxt = S_SM_DRN;
      end
      S_SM_DRN: begin
        cmd.mode  = MODE_SUM;
        state_nxt = S_SM_WR;
      end
      S_SM_WR: begin
        cmd.mode   = MODE_SUM;
        cmd.pix_wr = 1'b1;
        if (st.pix_last) begin
          computed_nxt = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          state_nxt = S_SM_PIX;
        end
      end
      S_RD: begin
        // sum word arrives: start divide, then wait for it and a free output
        cmd.div_start = start_r;
        if (!start_r && st.div_done && st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (cfg_we) begin
      computed_nxt = 1'b0;
    end
  end

  // the divide starts the cycle after the store read is issued
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      computed_r <= 1'b0;
      start_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      computed_r <= computed_nxt;
      start_r    <= cmd.rd_issue;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/blanket_fractal_roughness_map.sv =====
// Blanket roughness map: a read gives its item after a store read, a 21-step restoring
// divide and an output load, one item at a time.
// After the last pixel the walk reads 3x3 taps on the pixel store port per interior pixel
// and 5x5 taps on the blanket store port per 5x5-window pixel; border pixels take no taps.
// Synchronous reset clears control state only; the stores hold no reset value.
// Depends on bfrm_pkg, bfrm_ctrl and bfrm_datapath.
`default_nettype none
module blanket_fractal_roughness_map (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire bfrm_pkg::in_item_t        in_item,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output bfrm_pkg::out_item_t            out_item,
  input  wire logic                      cfg_we,
  input  wire logic                      cfg_idx,
  input  wire logic [bfrm_pkg::CFGW-1:0] cfg_data
);
  import bfrm_pkg::*;

  cmd_t    cmd;
  status_t st;

  bfrm_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_opcode(in_item.opcode), .in_stall,
    .cfg_we, .st, .cmd);

  bfrm_datapath u_dp (
    .clk, .rst_n, .cfg_we, .cfg_idx, .cfg_data, .pixel_in(in_item.pixel_in),
    .cmd, .st, .out_valid, .out_stall, .out_item);
endmodule
`default_nettype wire

// ===== rtl/bfrm_checker.sv =====
// Port-level checks for the blanket roughness map, bound to the top level.
// Depends on bfrm_pkg.
`default_nettype none
module bfrm_checker (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      in_valid,
  input wire logic                      in_stall,
  input wire bfrm_pkg::in_item_t        in_item,
  input wire logic                      out_valid,
  input wire logic                      out_stall,
  input wire bfrm_pkg::out_item_t       out_item
);
  import bfrm_pkg::*;

  // a waiting item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result item changed while stalled");

  // reset empties the output register
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result item present after reset");

  // a write never raises a result
  a_write_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_item.opcode == OP_WRITE |=> !$rose(out_valid))
    else $error("result item after a pixel write");

  // a new result only follows a busy stretch
  a_busy_before: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result item without a read in progress");
endmodule

bind blanket_fractal_roughness_map bfrm_checker u_bfrm_checker (.*);
`default_nettype wire
